>>> hw/rtl/lpst_pkg.sv
package lpst_pkg;

  localparam int COORD_BITS      = 15;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int ANGLE_EPS       = 1;
  localparam int CORDIC_STEPS    = 18;
  localparam int TAB_LEN         = 30;

  localparam int VEC_SHIFT = 46 - COORD_BITS;
  localparam int RHO_GUARD = (60 - 2 * COORD_BITS) / 2;

  // datapath widths
  localparam int D_W      = COORD_BITS + 1;          // endpoint difference
  localparam int V_W      = D_W + 1;                 // negated difference
  localparam int CXY_W    = V_W + VEC_SHIFT + 2;     // rotator x/y with gain headroom
  localparam int Z_W      = 64;                      // angle accumulator, Q60
  localparam int LEN_W    = 2 * D_W;                 // squared length
  localparam int N_W      = 2 * COORD_BITS + 2;      // cross product
  localparam int SQ_IN_W  = LEN_W + 2 * RHO_GUARD;   // root radicand
  localparam int SQ_STEPS = SQ_IN_W / 2;
  localparam int S_W      = SQ_STEPS;                // root width
  localparam int Q_W      = 24;                      // rho magnitude, 8 fraction bits
  localparam int NUM_W    = N_W + 8 + RHO_GUARD;     // dividend
  localparam int ANG_W    = ANGLE_FRAC_BITS + 4;
  localparam int RHO_W    = Q_W;
  localparam int DIFF_W   = ANG_W + 2;
  localparam int CFG_W    = 17;
  localparam int AGAP_W   = 17;
  localparam int DGAP_W   = 24;
  localparam int ATHR_W   = 17;
  localparam int DTHR_W   = 16;

  localparam logic [ATHR_W-1:0] ATHR_RESET = ATHR_W'(567);
  localparam logic [DTHR_W-1:0] DTHR_RESET = DTHR_W'(20);

  // s1, s2, entry, root steps, divider prep, divider steps, fold
  localparam int SEG_LAT = 3 + SQ_STEPS + 1 + Q_W + 1;

  localparam logic signed [63:0] PI_Q60 = 64'sh3243F6A8885A308D;
  localparam longint PI_F =
    (PI_Q60 + (64'sd1 <<< (59 - ANGLE_FRAC_BITS))) >>> (60 - ANGLE_FRAC_BITS);
  localparam longint HALF_PI_F =
    (PI_Q60 + (64'sd1 <<< (60 - ANGLE_FRAC_BITS))) >>> (61 - ANGLE_FRAC_BITS);
  localparam longint TWO_PI_F = 2 * PI_F;

  typedef enum logic [0:0] {
    REG_ANGLE_THR = 1'b0,
    REG_DIST_THR  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                    ok;
    logic signed [ANG_W-1:0] theta;
    logic [RHO_W-1:0]        rho;
  } seg_res_t;

  // arctangent of 2^-i in Q60: pi/4 for i = 0, else by its power series, evaluated at elaboration
  function automatic logic signed [63:0] atan_q60(input int i);
    logic signed [63:0] acc;
    logic signed [63:0] term;
    int e;
    acc = '0;
    if (i == 0) begin
      acc = PI_Q60 >>> 2;
    end else begin
      for (int k = 0; k < 31; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e >= 0) begin
          term = (64'sd1 <<< e) / 64'(2 * k + 1);
          if ((k & 1) != 0) acc = acc - term;
          else acc = acc + term;
        end
      end
    end
    return acc;
  endfunction

  localparam logic signed [63:0] ATAN_TAB [TAB_LEN] = '{
    atan_q60(0),  atan_q60(1),  atan_q60(2),  atan_q60(3),  atan_q60(4),
    atan_q60(5),  atan_q60(6),  atan_q60(7),  atan_q60(8),  atan_q60(9),
    atan_q60(10), atan_q60(11), atan_q60(12), atan_q60(13), atan_q60(14),
    atan_q60(15), atan_q60(16), atan_q60(17), atan_q60(18), atan_q60(19),
    atan_q60(20), atan_q60(21), atan_q60(22), atan_q60(23), atan_q60(24),
    atan_q60(25), atan_q60(26), atan_q60(27), atan_q60(28), atan_q60(29)
  };

endpackage

>>> hw/rtl/lpst_seg.sv
module lpst_seg #(
  parameter int CORDIC_STEPS = lpst_pkg::CORDIC_STEPS
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [lpst_pkg::COORD_BITS-1:0] x1,
  input  logic signed [lpst_pkg::COORD_BITS-1:0] y1,
  input  logic signed [lpst_pkg::COORD_BITS-1:0] x2,
  input  logic signed [lpst_pkg::COORD_BITS-1:0] y2,
  output lpst_pkg::seg_res_t                     res
);

  localparam int D_W      = lpst_pkg::D_W;
  localparam int V_W      = lpst_pkg::V_W;
  localparam int CXY_W    = lpst_pkg::CXY_W;
  localparam int Z_W      = lpst_pkg::Z_W;
  localparam int LEN_W    = lpst_pkg::LEN_W;
  localparam int N_W      = lpst_pkg::N_W;
  localparam int CB       = lpst_pkg::COORD_BITS;
  localparam int SQ_IN_W  = lpst_pkg::SQ_IN_W;
  localparam int SQ_STEPS = lpst_pkg::SQ_STEPS;
  localparam int S_W      = lpst_pkg::S_W;
  localparam int Q_W      = lpst_pkg::Q_W;
  localparam int NUM_W    = lpst_pkg::NUM_W;
  localparam int ANG_W    = lpst_pkg::ANG_W;
  localparam int F        = lpst_pkg::ANGLE_FRAC_BITS;

  localparam logic signed [ANG_W-1:0] PI_A  = ANG_W'(lpst_pkg::PI_F);
  localparam logic signed [ANG_W-1:0] TWO_A = ANG_W'(lpst_pkg::TWO_PI_F);
  localparam logic signed [ANG_W-1:0] EPS_A = ANG_W'(lpst_pkg::ANGLE_EPS);

  typedef struct packed {
    logic signed [CXY_W-1:0] x;
    logic signed [CXY_W-1:0] y;
    logic signed [Z_W-1:0]   z;
    logic [SQ_IN_W-1:0]      rem;
    logic [SQ_IN_W-1:0]      root;
    logic signed [N_W-1:0]   n;
    logic                    ok;
  } sq_stage_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] theta;
    logic [NUM_W-1:0]        rem;
    logic [Q_W-1:0]          q;
    logic [S_W-1:0]          s;
    logic                    nneg;
    logic                    ok;
  } dv_stage_t;

  // stage 1: differences
  logic signed [D_W-1:0] dx1, dy1;
  logic signed [CB-1:0]  x2r, y2r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= D_W'(x2) - D_W'(x1);
      dy1 <= D_W'(y2) - D_W'(y1);
      x2r <= x2;
      y2r <= y2;
    end
  end

  // stage 2: products
  logic signed [2*D_W-1:0]  sqx, sqy;
  logic signed [D_W+CB-1:0] px, py;
  logic signed [D_W-1:0]    dx2, dy2;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= dx1 * dx1;
      sqy <= dy1 * dy1;
      px  <= dx1 * y2r;
      py  <= dy1 * x2r;
      dx2 <= dx1;
      dy2 <= dy1;
    end
  end

  // stage 3: length, cross product, rotator pre-rotation
  sq_stage_t st [SQ_STEPS+1];
  sq_stage_t st0_next;
  logic [LEN_W-1:0]      len2;
  logic signed [V_W-1:0] vx, vy;

  always_comb begin
    len2 = LEN_W'(unsigned'(sqx)) + LEN_W'(unsigned'(sqy));
    vx   = -V_W'(dy2);
    vy   = V_W'(dx2);
    st0_next.rem  = SQ_IN_W'(len2) << (2 * lpst_pkg::RHO_GUARD);
    st0_next.root = '0;
    st0_next.n    = N_W'(px) - N_W'(py);
    st0_next.ok   = (len2 != '0);
    if (vx < 0) begin
      st0_next.z = (vy >= 0) ? lpst_pkg::PI_Q60 : -lpst_pkg::PI_Q60;
      st0_next.x = CXY_W'(-vx) <<< lpst_pkg::VEC_SHIFT;
      st0_next.y = CXY_W'(-vy) <<< lpst_pkg::VEC_SHIFT;
    end else begin
      st0_next.z = '0;
      st0_next.x = CXY_W'(vx) <<< lpst_pkg::VEC_SHIFT;
      st0_next.y = CXY_W'(vy) <<< lpst_pkg::VEC_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= st0_next;
    end
  end

  // one root bit per stage; the rotator runs in the first CORDIC_STEPS of them
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    localparam int K = SQ_STEPS - 1 - i;
    sq_stage_t               nxt;
    logic [SQ_IN_W:0]        trial;
    logic signed [CXY_W-1:0] xi, yi, cx, cy;
    logic signed [Z_W-1:0]   zi, cz;

    assign xi = st[i].x;
    assign yi = st[i].y;
    assign zi = st[i].z;

    if (i < CORDIC_STEPS) begin : g_rot
      always_comb begin
        if (yi > 0) begin
          cx = xi + (yi >>> i);
          cy = yi - (xi >>> i);
          cz = zi + lpst_pkg::ATAN_TAB[i];
        end else begin
          cx = xi - (yi >>> i);
          cy = yi + (xi >>> i);
          cz = zi - lpst_pkg::ATAN_TAB[i];
        end
      end
    end else begin : g_pass
      assign cx = xi;
      assign cy = yi;
      assign cz = zi;
    end

    always_comb begin
      nxt   = st[i];
      nxt.x = cx;
      nxt.y = cy;
      nxt.z = cz;
      trial = {1'b0, st[i].root} + ((SQ_IN_W+1)'(1) << (2 * K));
      if ({1'b0, st[i].rem} >= trial) begin
        nxt.rem  = st[i].rem - trial[SQ_IN_W-1:0];
        nxt.root = (st[i].root >> 1) + (SQ_IN_W'(1) << (2 * K));
      end else begin
        nxt.root = st[i].root >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  // divider prep: round angle, form dividend
  dv_stage_t dv [Q_W+1];
  dv_stage_t dv0_next;
  logic signed [Z_W-1:0] zr;
  logic signed [N_W-1:0] nn;
  logic [N_W-1:0]        nabs;
  logic [S_W-1:0]        sroot;

  always_comb begin
    zr    = st[SQ_STEPS].z + (Z_W'(1) <<< (59 - F));
    nn    = st[SQ_STEPS].n;
    nabs  = (nn < 0) ? unsigned'(-nn) : unsigned'(nn);
    sroot = st[SQ_STEPS].root[S_W-1:0];
    dv0_next.theta = ANG_W'(zr >>> (60 - F));
    dv0_next.rem   = (NUM_W'(nabs) << (8 + lpst_pkg::RHO_GUARD)) + NUM_W'(sroot >> 1);
    dv0_next.q     = '0;
    dv0_next.s     = sroot;
    dv0_next.nneg  = (nn < 0);
    dv0_next.ok    = st[SQ_STEPS].ok;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= dv0_next;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    localparam int B = Q_W - 1 - j;
    dv_stage_t        nxt;
    logic [NUM_W-1:0] sh;

    always_comb begin
      nxt = dv[j];
      sh  = NUM_W'(dv[j].s) << B;
      if (dv[j].rem >= sh) begin
        nxt.rem  = dv[j].rem - sh;
        nxt.q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1] <= nxt;
      end
    end
  end

  // fold angle into range and make rho non-negative
  lpst_pkg::seg_res_t res_next;
  logic signed [ANG_W-1:0] t, tw;
  logic sg, mnz;

  always_comb begin
    t   = dv[Q_W].theta;
    sg  = dv[Q_W].nneg;
    mnz = (dv[Q_W].q != '0);
    if (t < 0) begin
      t  = t + PI_A;
      sg = ~sg;
    end
    if (t > PI_A) begin
      if (t - PI_A < EPS_A) begin
        t  = '0;
        sg = ~sg;
      end else begin
        t = t - PI_A;
      end
    end
    tw = t - TWO_A;
    if (sg && mnz) begin
      if (t < 0) begin
        t = t + PI_A;
      end else if (t < EPS_A || (tw > -EPS_A && tw < EPS_A)) begin
        t = '0;
      end else begin
        t = t - PI_A;
      end
    end
    res_next.ok    = dv[Q_W].ok;
    res_next.theta = t;
    res_next.rho   = dv[Q_W].q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

>>> hw/rtl/line_pair_similarity_test_core.sv
// Throughput: one word per cycle; the root and divider stages are fully
// pipelined, one root bit and one quotient bit per stage.
// A stalled output holds the whole pipeline in place.
// Reset (rst, synchronous) clears all valid bits and loads the thresholds
// with 567 (angle) and 20 (distance).
module line_pair_similarity_test_core #(
  parameter int CORDIC_STEPS = lpst_pkg::CORDIC_STEPS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  lpst_pkg::reg_idx_t          cfg_index,
  input  logic [lpst_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [119:0]                s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // similar, angle_gap, distance_gap, zero fill
  output logic [47:0]                 m_tdata,
  // degenerate
  output logic                        m_tuser
);

  localparam int CB      = lpst_pkg::COORD_BITS;
  localparam int LAT     = lpst_pkg::SEG_LAT;
  localparam int DIFF_W  = lpst_pkg::DIFF_W;
  localparam int RHO_W   = lpst_pkg::RHO_W;
  localparam int AGAP_W  = lpst_pkg::AGAP_W;
  localparam int DGAP_W  = lpst_pkg::DGAP_W;
  localparam int ATHR_W  = lpst_pkg::ATHR_W;
  localparam int DTHR_W  = lpst_pkg::DTHR_W;

  localparam logic signed [DIFF_W-1:0] PI_D   = DIFF_W'(lpst_pkg::PI_F);
  localparam logic signed [DIFF_W-1:0] HALF_D = DIFF_W'(lpst_pkg::HALF_PI_F);
  localparam logic signed [DIFF_W-1:0] TWO_D  = DIFF_W'(lpst_pkg::TWO_PI_F);
  localparam logic signed [DIFF_W-1:0] EPS_D  = DIFF_W'(lpst_pkg::ANGLE_EPS);

  logic en;
  logic [LAT+1:0] vld;

  assign en       = ~vld[LAT+1] | m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT:0], s_tvalid};
    end
  end

  logic [ATHR_W-1:0] athr;
  logic [DTHR_W-1:0] dthr;

  always_ff @(posedge clk) begin
    if (rst) begin
      athr <= lpst_pkg::ATHR_RESET;
      dthr <= lpst_pkg::DTHR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpst_pkg::REG_ANGLE_THR: athr <= cfg_data[ATHR_W-1:0];
        lpst_pkg::REG_DIST_THR:  dthr <= cfg_data[DTHR_W-1:0];
        default: ;
      endcase
    end
  end

  lpst_pkg::seg_res_t ra, rb;

  lpst_seg #(.CORDIC_STEPS(CORDIC_STEPS)) u_seg_a (
    .clk (clk),
    .en  (en),
    .x1  (s_tdata[0*CB +: CB]),
    .y1  (s_tdata[1*CB +: CB]),
    .x2  (s_tdata[2*CB +: CB]),
    .y2  (s_tdata[3*CB +: CB]),
    .res (ra)
  );

  lpst_seg #(.CORDIC_STEPS(CORDIC_STEPS)) u_seg_b (
    .clk (clk),
    .en  (en),
    .x1  (s_tdata[4*CB +: CB]),
    .y1  (s_tdata[5*CB +: CB]),
    .x2  (s_tdata[6*CB +: CB]),
    .y2  (s_tdata[7*CB +: CB]),
    .res (rb)
  );

  // stage A: wrapped angle difference, rho difference
  logic signed [DIFF_W-1:0] d, dn;
  logic signed [RHO_W:0]    dr;
  logic [RHO_W-1:0]         dg_next, dg;
  logic                     okp;

  always_comb begin
    d = DIFF_W'(ra.theta) - DIFF_W'(rb.theta);
    if (d < 0) d = d + TWO_D;
    if (d > TWO_D) d = d - TWO_D;
    dr      = (RHO_W+1)'(ra.rho) - (RHO_W+1)'(rb.rho);
    dg_next = (dr < 0) ? RHO_W'(-dr) : RHO_W'(dr);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn  <= d;
      dg  <= dg_next;
      okp <= ra.ok & rb.ok;
    end
  end

  // stage B: smaller included angle, threshold tests
  logic signed [DIFF_W-1:0] m, dw;
  logic [AGAP_W-1:0]        ag;
  logic                     near_zero;

  always_comb begin
    dw        = dn - TWO_D;
    near_zero = (dn > -EPS_D && dn < EPS_D) || (dw > -EPS_D && dw < EPS_D);
    m         = (dn > PI_D) ? TWO_D - dn : dn;
    if (m > HALF_D) m = PI_D - m;
    ag = near_zero ? '0 : m[AGAP_W-1:0];
  end

  logic             sim_o, deg_o;
  logic [AGAP_W-1:0] ag_o;
  logic [DGAP_W-1:0] dg_o;

  always_ff @(posedge clk) begin
    if (en) begin
      if (okp) begin
        sim_o <= (ag < athr) && (DGAP_W'(dg) < {dthr, 8'h00});
        deg_o <= 1'b0;
        ag_o  <= ag;
        dg_o  <= DGAP_W'(dg);
      end else begin
        sim_o <= 1'b0;
        deg_o <= 1'b1;
        ag_o  <= '0;
        dg_o  <= '0;
      end
    end
  end

  assign m_tdata = {6'b0, dg_o, ag_o, sim_o};
  assign m_tuser = deg_o;

endmodule

>>> dv/line_pair_similarity_test_core_test.sv
module line_pair_similarity_test_core_test;

  localparam int LATENCY   = 62;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM  = 1030;

  typedef struct packed {
    logic [14:0] bey, bex, bsy, bsx, aey, aex, asy, asx;
  } pair_t;

  typedef struct {
    logic        similar;
    logic        degenerate;
    logic [16:0] angle_gap;
    logic [23:0] distance_gap;
  } verdict_t;

  typedef struct {
    pair_t    pair;
    logic     known;
    verdict_t res;
  } row_t;

  logic clk, rst;
  logic cfg_we;
  lpst_pkg::reg_idx_t cfg_index;
  logic [lpst_pkg::CFG_W-1:0] cfg_data;
  logic s_tvalid, s_tready;
  logic [119:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [47:0] m_tdata;
  logic m_tuser;

  line_pair_similarity_test_core dut (.*);

  logic [63:0] atan_q60_tab [30];
  longint angle_thr, dist_thr;
  verdict_t verdict_q [$];
  int fails = 0;
  int row_errs;
  int idle_cycles;
  logic stall_on;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void build_atan();
    longint acc, term;
    int e;
    atan_q60_tab[0] = lpst_pkg::PI_Q60 >>> 2;
    for (int i = 1; i < 30; i++) begin
      acc = 0;
      for (int k = 0; k < 31; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e >= 0) begin
          term = (64'sd1 <<< e) / longint'(2 * k + 1);
          acc = (k & 1) ? acc - term : acc + term;
        end
      end
      atan_q60_tab[i] = acc;
    end
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint vy, longint vx);
    longint x, y, z, nx, ny;
    x = vx <<< lpst_pkg::VEC_SHIFT;
    y = vy <<< lpst_pkg::VEC_SHIFT;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? lpst_pkg::PI_Q60 : -lpst_pkg::PI_Q60;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < lpst_pkg::CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + asr(y, i); ny = y - asr(x, i); z += atan_q60_tab[i];
      end else begin
        nx = x - asr(y, i); ny = y + asr(x, i); z -= atan_q60_tab[i];
      end
      x = nx; y = ny;
    end
    return asr(z + (64'sd1 <<< (59 - lpst_pkg::ANGLE_FRAC_BITS)),
               60 - lpst_pkg::ANGLE_FRAC_BITS);
  endfunction

  // Hough normal form of one segment; returns 0 for zero length
  function automatic bit normal_form(longint x1, longint y1, longint x2, longint y2,
                                     output longint th, output longint r);
    longint dx, dy, n;
    longint unsigned len2, s, m;
    dx = x2 - x1; dy = y2 - y1;
    len2 = dx * dx + dy * dy;
    th = 0; r = 0;
    if (len2 == 0) return 0;
    n = dx * y2 - dy * x2;
    s = int_sqrt(len2 << (2 * lpst_pkg::RHO_GUARD));
    m = ((longint'(mag(n)) << (8 + lpst_pkg::RHO_GUARD)) + s / 2) / s;
    r = n < 0 ? -longint'(m) : longint'(m);
    th = vector_angle(dx, -dy);
    if (th < 0) begin th += lpst_pkg::PI_F; r = -r; end
    if (th > lpst_pkg::PI_F) begin
      if (th - lpst_pkg::PI_F < lpst_pkg::ANGLE_EPS) begin th = 0; r = -r; end
      else th -= lpst_pkg::PI_F;
    end
    if (r < 0) begin
      r = -r;
      if (th < 0) th += lpst_pkg::PI_F;
      else if (mag(th) < lpst_pkg::ANGLE_EPS ||
               mag(th - lpst_pkg::TWO_PI_F) < lpst_pkg::ANGLE_EPS) th = 0;
      else th -= lpst_pkg::PI_F;
    end
    return 1;
  endfunction

  function automatic verdict_t predict_similarity(pair_t p);
    verdict_t v;
    longint ta, ra, tb, rb, d, m, dg;
    bit oka, okb;
    oka = normal_form(longint'($signed(p.asx)), longint'($signed(p.asy)),
                      longint'($signed(p.aex)), longint'($signed(p.aey)), ta, ra);
    okb = normal_form(longint'($signed(p.bsx)), longint'($signed(p.bsy)),
                      longint'($signed(p.bex)), longint'($signed(p.bey)), tb, rb);
    v = '{0, 1, 0, 0};
    if (!oka || !okb) return v;
    d = ta - tb;
    if (d < 0) d += lpst_pkg::TWO_PI_F;
    if (d > lpst_pkg::TWO_PI_F) d -= lpst_pkg::TWO_PI_F;
    if (mag(d - lpst_pkg::TWO_PI_F) < lpst_pkg::ANGLE_EPS || mag(d) < lpst_pkg::ANGLE_EPS)
      m = 0;
    else begin
      m = (d > lpst_pkg::PI_F) ? lpst_pkg::TWO_PI_F - d : d;
      if (m > lpst_pkg::HALF_PI_F) m = lpst_pkg::PI_F - m;
    end
    dg = mag(ra - rb);
    v.similar = (m < angle_thr) && (dg < (dist_thr << 8));
    v.degenerate = 0;
    v.angle_gap = m[16:0];
    v.distance_gap = dg[23:0];
    return v;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int sel;
    p = 120'({$urandom, $urandom, $urandom, $urandom});
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      // second segment a small jitter of the first, so similar often hits
      p.bsx = p.asx + 15'($urandom_range(0, 6) - 3);
      p.bsy = p.asy + 15'($urandom_range(0, 6) - 3);
      p.bex = p.aex + 15'($urandom_range(0, 6) - 3);
      p.bey = p.aey + 15'($urandom_range(0, 6) - 3);
    end else if (sel < 6) begin
      // short segments around a small window
      p.asx = 15'($urandom_range(0, 200) - 100); p.asy = 15'($urandom_range(0, 200) - 100);
      p.aex = p.asx + 15'($urandom_range(0, 20) - 10);
      p.aey = p.asy + 15'($urandom_range(0, 20) - 10);
      p.bsx = p.asx + 15'($urandom_range(0, 4)); p.bsy = p.asy + 15'($urandom_range(0, 4));
      p.bex = p.aex + 15'($urandom_range(0, 4)); p.bey = p.aey + 15'($urandom_range(0, 4));
    end else if (sel == 6) begin
      if ($urandom_range(0, 1)) {p.aex, p.aey} = {p.asx, p.asy};
      else {p.bex, p.bey} = {p.bsx, p.bsy};
    end
    return p;
  endfunction

  task automatic write_thresholds(longint a, longint d);
    cfg_we <= 1; cfg_index <= lpst_pkg::REG_ANGLE_THR; cfg_data <= lpst_pkg::CFG_W'(a);
    @(posedge clk);
    cfg_index <= lpst_pkg::REG_DIST_THR; cfg_data <= lpst_pkg::CFG_W'(d);
    @(posedge clk);
    cfg_we <= 0;
    angle_thr = a & 17'h1FFFF;
    dist_thr = d & 16'hFFFF;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_pair(pair_t p, bit known, verdict_t res);
    verdict_t v;
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3))
        @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= p;
    do @(posedge clk); while (!s_tready);
    v = predict_similarity(p);
    if (known && v != res) begin
      $display("%0t predictor disagrees with table row: exp %p got %p", $time, res, v);
      row_errs++;
    end
    verdict_q.push_back(known ? res : v);
  endtask

  // receiver: random stalls, compare each word with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      stall_on <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t unexpected result word %h", $time, m_tdata);
          fails++;
        end else begin
          verdict_t e;
          e = verdict_q.pop_front();
          if (m_tdata[0] !== e.similar || m_tuser !== e.degenerate ||
              m_tdata[17:1] !== e.angle_gap || m_tdata[41:18] !== e.distance_gap) begin
            $display("%0t mismatch: exp sim %0d deg %0d ang %0d dist %0d, %s",
                     $time, e.similar, e.degenerate, e.angle_gap, e.distance_gap,
                     $sformatf("got sim %0d deg %0d ang %0d dist %0d",
                               m_tdata[0], m_tuser, m_tdata[17:1], m_tdata[41:18]));
            fails++;
          end
        end
      end
      if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
      m_tready <= stall_on ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 4) != 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("** line_pair_similarity_test_core: FAILED **");
      $finish;
    end
  end

  row_t rows [$];

  task automatic add_row(pair_t p, bit known, verdict_t r);
    rows.push_back('{p, known, r});
  endtask

  initial begin
    pair_t p;
    verdict_t none, degen;
    none = '{0, 0, 0, 0};
    degen = '{0, 1, 0, 0};
    row_errs = 0;
    rst = 1; cfg_we = 0; cfg_index = lpst_pkg::REG_ANGLE_THR; cfg_data = 0;
    s_tvalid = 0; s_tdata = 0;
    build_atan();
    angle_thr = 567; dist_thr = 20;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table
    add_row('0, 1, degen);
    p = '0; p.aex = 15'd100; add_row(p, 1, degen);                // second zero length
    p = '0; p.bex = 15'd100; add_row(p, 1, degen);
    p = '0; p.aex = 15'd100; p.bex = 15'd50; add_row(p, 1, '{1, 0, 0, 0}); // same line
    p = '{15'h3FFF, 15'h3FFF, 15'h4000, 15'h4000, 15'h3FFF, 15'h3FFF, 15'h4000, 15'h4000};
    add_row(p, 0, none);
    p = '{15'h4000, 15'h3FFF, 15'h3FFF, 15'h4000, 15'h4000, 15'h4000, 15'h3FFF, 15'h3FFF};
    add_row(p, 0, none);
    p = '{15'h7FFF, 15'd0, 15'h7FFF, 15'h4000, 15'd1, 15'd0, 15'd1, 15'h3FFF};
    add_row(p, 0, none);
    p = '0; p.aex = 15'd10; p.bey = 15'd10; add_row(p, 0, none);   // perpendicular
    p = '0; p.aex = 15'h7FF6; p.bex = 15'd10; add_row(p, 0, none);  // reversed direction
    p = '0; p.aey = 15'd10; p.bey = 15'h7FF6; add_row(p, 0, none);
    p = '0; p.asy = 15'd5; p.aey = 15'd5; p.aex = 15'd9;
    p.bsy = 15'h7FFB; p.bey = 15'h7FFB; p.bex = 15'h7FF7; add_row(p, 0, none);
    p = '0; p.asx = 15'd3; p.aex = 15'd3; p.aey = 15'h7FF0;
    p.bex = 15'd1; p.bey = 15'd1; add_row(p, 0, none);
    p = '0; p.aex = 15'd1; p.aey = 15'h7FFF; p.bex = 15'h7FFF; p.bey = 15'd1; add_row(p, 0, none);
    foreach (rows[i]) send_pair(rows[i].pair, rows[i].known, rows[i].res);

    // sender pauses until the pipeline is empty, then thresholds change
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_thresholds(102944, 46341);
        1: write_thresholds(0, 0);
        2: write_thresholds(131071, 65535);
        3: write_thresholds(3000, 3);
        default: write_thresholds(567, 20);
      endcase
      for (int k = 0; k < N_RANDOM / 5; k++) send_pair(rand_pair(), 0, none);
      drain();
    end

    if (fails == 0 && row_errs == 0) $display("** line_pair_similarity_test_core: PASSED **");
    else $display("** line_pair_similarity_test_core: FAILED **");
    $finish;
  end

endmodule

>>> line_pair_similarity_test_core.f
hw/rtl/lpst_pkg.sv
hw/rtl/lpst_seg.sv
hw/rtl/line_pair_similarity_test_core.sv
dv/line_pair_similarity_test_core_test.sv
